@@ rtl/rpt_pkg.sv @@
// shared types and constants for the retained packet table
package rpt_pkg;

    localparam int KEY_BITS = 32;
    localparam int EXT_HANDLE_BITS = 16;
    localparam int OUT_COUNT_BITS = 5;
    localparam int IN_TDATA_BITS = 48;
    localparam int IN_TUSER_BITS = 2;
    localparam int OUT_TDATA_BITS = 48;

    localparam logic [1:0] MODE_STORE = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_PURGE_UPTO = 2'd2;
    localparam logic [1:0] MODE_PURGE_EXACT = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic start;
        logic walk;
        logic finish;
    } rpt_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_free;
    } rpt_status_t;

endpackage

@@ rtl/rpt_ram.sv @@
// generic simple dual port ram with registered read
module rpt_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [ADDR_BITS-1:0]   waddr,
    input  logic [WIDTH-1:0]       wdata,
    input  logic                   re,
    input  logic [ADDR_BITS-1:0]   raddr,
    output logic [WIDTH-1:0]       rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rpt_ctrl.sv @@
// controller state machine sequencing walk and finish of one word
module rpt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rpt_pkg::rpt_status_t status,
    output rpt_pkg::rpt_cmd_t    cmd
);
    rpt_pkg::state_t state_reg;
    rpt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready = 1'b0;
        cmd = '0;
        case (state_reg)
            rpt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    state_next = rpt_pkg::ST_WALK;
                end
            end
            rpt_pkg::ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_done)
                begin
                    state_next = rpt_pkg::ST_FINISH;
                end
            end
            rpt_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = rpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rpt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/rpt_dp.sv @@
// datapath: entry ram as a ring, walk pipeline, compaction and result register
module rpt_dp #(
    parameter int DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rpt_pkg::rpt_cmd_t                     cmd,
    output rpt_pkg::rpt_status_t                  status,
    input  logic [1:0]                            in_mode,
    input  logic [rpt_pkg::KEY_BITS-1:0]          in_key,
    input  logic [rpt_pkg::EXT_HANDLE_BITS-1:0]   in_handle,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [rpt_pkg::OUT_TDATA_BITS-1:0]    out_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int HW = HANDLE_BITS;
    localparam int EW = rpt_pkg::KEY_BITS + HW;
    localparam int OCW = rpt_pkg::OUT_COUNT_BITS;
    localparam int XHW = rpt_pkg::EXT_HANDLE_BITS;

    function automatic logic [AW-1:0] addr_inc(input logic [AW-1:0] a);
        logic [AW-1:0] r;
        if (a == AW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = a + 1'b1;
        end
        return r;
    endfunction

    // control state
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pend_reg, pend_next;
    logic          out_valid_reg, out_valid_next;

    // per word working registers
    logic [1:0]                   mode_reg, mode_next;
    logic [rpt_pkg::KEY_BITS-1:0] key_reg, key_next;
    logic [HW-1:0]                handle_reg, handle_next;
    logic [CW-1:0]                rd_idx_reg, rd_idx_next;
    logic [AW-1:0]                rd_addr_reg, rd_addr_next;
    logic [AW-1:0]                q_addr_reg, q_addr_next;
    logic [CW-1:0]                wr_idx_reg, wr_idx_next;
    logic [AW-1:0]                wr_addr_reg, wr_addr_next;
    logic                         hit_reg, hit_next;
    logic [AW-1:0]                hit_addr_reg, hit_addr_next;
    logic [HW-1:0]                found_reg, found_next;
    logic                         first_reg, first_next;
    logic [HW-1:0]                ev_reg, ev_next;
    logic [CW-1:0]                removed_reg, removed_next;
    logic [rpt_pkg::OUT_TDATA_BITS-1:0] out_data_reg, out_data_next;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [EW-1:0]                ram_wdata;
    logic                         ram_re;
    logic [EW-1:0]                ram_rdata;
    logic [rpt_pkg::KEY_BITS-1:0] r_key;
    logic [HW-1:0]                r_handle;
    logic                         is_store, is_lookup, is_purge, full, key_eq, key_le, drop;
    logic [CW-1:0]                occ_new;
    logic                         o_hit, o_evicted;
    logic [XHW-1:0]               o_found, o_ev_handle;
    logic [OCW-1:0]               o_removed;

    rpt_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(rd_addr_reg),
        .rdata(ram_rdata)
    );

    assign r_key     = ram_rdata[HW +: rpt_pkg::KEY_BITS];
    assign r_handle  = ram_rdata[HW-1:0];
    assign is_store  = (mode_reg == rpt_pkg::MODE_STORE);
    assign is_lookup = (mode_reg == rpt_pkg::MODE_LOOKUP);
    assign is_purge  = (mode_reg == rpt_pkg::MODE_PURGE_UPTO)
                    || (mode_reg == rpt_pkg::MODE_PURGE_EXACT);
    assign full      = (count_reg == CW'(DEPTH));
    assign key_eq    = (r_key == key_reg);
    assign key_le    = (r_key <= key_reg);
    assign drop      = (mode_reg == rpt_pkg::MODE_PURGE_EXACT) ? key_eq : key_le;
    assign ram_re    = cmd.walk && (rd_idx_reg < count_reg);

    assign status.walk_done = (rd_idx_reg == count_reg) && !pend_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    // write port: compaction during the walk, store at finish
    always_comb
    begin
        ram_we = 1'b0;
        ram_waddr = wr_addr_reg;
        ram_wdata = ram_rdata;
        if (cmd.finish && is_store)
        begin
            ram_we = 1'b1;
            ram_waddr = hit_reg ? hit_addr_reg : rd_addr_reg;
            ram_wdata = {key_reg, handle_reg};
        end
        else if (cmd.walk && pend_reg && is_purge && !drop)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        case (mode_reg)
            rpt_pkg::MODE_STORE:       occ_new = (hit_reg || full) ? count_reg : count_reg + 1'b1;
            rpt_pkg::MODE_LOOKUP:      occ_new = count_reg;
            rpt_pkg::MODE_PURGE_UPTO:  occ_new = wr_idx_reg;
            rpt_pkg::MODE_PURGE_EXACT: occ_new = wr_idx_reg;
            default:                   occ_new = count_reg;
        endcase
        o_hit       = (is_store || is_lookup) && hit_reg;
        o_found     = (is_lookup && hit_reg) ? XHW'(found_reg) : '0;
        o_evicted   = is_store && !hit_reg && full;
        o_ev_handle = o_evicted ? XHW'(ev_reg) : '0;
        o_removed   = is_purge ? OCW'(removed_reg) : '0;
    end

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        pend_next      = 1'b0;
        mode_next      = mode_reg;
        key_next       = key_reg;
        handle_next    = handle_reg;
        rd_idx_next    = rd_idx_reg;
        rd_addr_next   = rd_addr_reg;
        q_addr_next    = q_addr_reg;
        wr_idx_next    = wr_idx_reg;
        wr_addr_next   = wr_addr_reg;
        hit_next       = hit_reg;
        hit_addr_next  = hit_addr_reg;
        found_next     = found_reg;
        first_next     = first_reg;
        ev_next        = ev_reg;
        removed_next   = removed_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.start)
        begin
            mode_next    = in_mode;
            key_next     = in_key;
            handle_next  = HW'(in_handle);
            rd_idx_next  = '0;
            rd_addr_next = head_reg;
            wr_idx_next  = '0;
            wr_addr_next = head_reg;
            hit_next     = 1'b0;
            first_next   = 1'b1;
            removed_next = '0;
        end

        if (cmd.walk)
        begin
            if (ram_re)
            begin
                rd_idx_next  = rd_idx_reg + 1'b1;
                rd_addr_next = addr_inc(rd_addr_reg);
                q_addr_next  = rd_addr_reg;
                pend_next    = 1'b1;
            end
            if (pend_reg)
            begin
                first_next = 1'b0;
                if (first_reg)
                begin
                    ev_next = r_handle;
                end
                if ((is_store || is_lookup) && key_eq && !hit_reg)
                begin
                    hit_next      = 1'b1;
                    hit_addr_next = q_addr_reg;
                    found_next    = r_handle;
                end
                if (is_purge)
                begin
                    if (drop)
                    begin
                        removed_next = removed_reg + 1'b1;
                    end
                    else
                    begin
                        wr_idx_next  = wr_idx_reg + 1'b1;
                        wr_addr_next = addr_inc(wr_addr_reg);
                    end
                end
            end
        end

        if (cmd.finish)
        begin
            if (is_store && !hit_reg && full)
            begin
                head_next = addr_inc(head_reg);
            end
            count_next     = occ_new;
            out_valid_next = 1'b1;
            out_data_next  = {4'b0, OCW'(occ_new), o_removed, o_ev_handle, o_evicted,
                              o_found, o_hit};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        key_reg      <= key_next;
        handle_reg   <= handle_next;
        rd_idx_reg   <= rd_idx_next;
        rd_addr_reg  <= rd_addr_next;
        q_addr_reg   <= q_addr_next;
        wr_idx_reg   <= wr_idx_next;
        wr_addr_reg  <= wr_addr_next;
        hit_reg      <= hit_next;
        hit_addr_reg <= hit_addr_next;
        found_reg    <= found_next;
        first_reg    <= first_next;
        ev_reg       <= ev_next;
        removed_reg  <= removed_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("occupancy above depth");

    a_purge_balance: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && is_purge |->
            (CW+1)'(removed_reg) + (CW+1)'(wr_idx_reg) == (CW+1)'(count_reg))
        else $error("purge lost or duplicated entries");

    a_compact_behind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> wr_idx_reg <= rd_idx_reg)
        else $error("compaction write ran ahead of reads");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished word not presented");

endmodule

@@ rtl/retained_packet_table.sv @@
// top level of the retained packet table
//
// channel   dir  tdata (lsb first)                                     tuser
// s_axis    in   entry_key[31:0], payload_handle[47:32]                mode[1:0]
// m_axis    out  hit[0], found_handle[16:1], evicted[17],              -
//                evicted_handle[33:18], removed_count[38:34],
//                occupancy[43:39], zero pad[47:44]
//
// a word steps through accept, then a walk that reads each held entry from the ram
// and compares it once its registered read returns, then finish.
// rst_n clears the occupancy and ring head; the entry ram needs no clearing.
// s_axis_tready is high between words, also while a result waits on m_axis;
// a stalled m_axis holds the next result in the finish state.
module retained_packet_table #(
    parameter int DEPTH = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [rpt_pkg::IN_TDATA_BITS-1:0]    s_axis_tdata,  // entry_key, payload_handle
    input  logic [rpt_pkg::IN_TUSER_BITS-1:0]    s_axis_tuser,  // mode
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [rpt_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata   // hit, found_handle, evicted,
                                                                // evicted_handle, removed_count,
                                                                // occupancy
);
    rpt_pkg::rpt_cmd_t    cmd;
    rpt_pkg::rpt_status_t status;

    rpt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    rpt_dp #(
        .DEPTH      (DEPTH),
        .HANDLE_BITS(HANDLE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .in_mode  (s_axis_tuser),
        .in_key   (s_axis_tdata[rpt_pkg::KEY_BITS-1:0]),
        .in_handle(s_axis_tdata[rpt_pkg::KEY_BITS +: rpt_pkg::EXT_HANDLE_BITS]),
        .out_ready(m_axis_tready),
        .out_valid(m_axis_tvalid),
        .out_data (m_axis_tdata)
    );

endmodule
